[rtl/core/dsps_pkg.sv]
// Package for the dual stepper phase sequencer.
// Holds the shared constants and the job type passed from front to back.
// No dependencies.
package dsps_pkg;

  localparam logic [3:0] PHASE_RESET = 4'b1001;
  localparam int DATA_BITS = 8;
  localparam int LATCH_IDX = DATA_BITS;
  localparam int IDX_W = $clog2(DATA_BITS + 1);
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [DATA_BITS-1:0] data;
    logic signed [15:0]   count_a;
    logic signed [15:0]   count_b;
  } job_t;

endpackage

[rtl/core/dual_stepper_phase_sequencer.sv]
// Top level of the dual stepper phase sequencer: front end, job queue, serializer.
// Depends on dsps_pkg, dsps_front, dsps_queue and dsps_back.
//
//   Channel   Handshake              Payload
//   in_       in_valid / in_ready    in_target_a, in_target_b
//   out_      out_valid / out_ready  out_serial_bit, out_latch_pulse, out_last,
//                                    out_count_a, out_count_b
//
// A tick that moves either motor yields nine transactions, one per cycle while
// out_ready is high; the serializer bounds the sustained rate.
// A tick already at target is taken and yields nothing.
// The front end keeps taking ticks while the queue has room, so the input
// stalls only when the queue is full, behind a serializer run or a
// stalled output; a tick at target waits then as well.
// Synchronous reset restores phases 1001 and counts of zero.
module dual_stepper_phase_sequencer #(
  parameter int QUEUE_DEPTH = dsps_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_target_a,
  input  logic signed [15:0] in_target_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_serial_bit,
  output logic               out_latch_pulse,
  output logic               out_last,
  output logic signed [15:0] out_count_a,
  output logic signed [15:0] out_count_b
);

  dsps_pkg::job_t     push_job;
  dsps_pkg::job_t     head_job;
  logic               q_full;
  logic               q_push;
  logic               q_pop;
  logic               q_valid;
  logic signed [15:0] front_count_a;
  logic signed [15:0] front_count_b;

  dsps_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_target_a (in_target_a),
    .in_target_b (in_target_b),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (push_job),
    .count_a     (front_count_a),
    .count_b     (front_count_b)
  );

  dsps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_job   (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_job   (head_job)
  );

  dsps_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_job           (head_job),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_serial_bit  (out_serial_bit),
    .out_latch_pulse (out_latch_pulse),
    .out_last        (out_last),
    .out_count_a     (out_count_a),
    .out_count_b     (out_count_b)
  );

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_latch_pulse && !out_serial_bit)
    else $error("latch transaction carries a data bit");

  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("serializer popped an empty queue");

  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready) |=> $stable(front_count_a) && $stable(front_count_b))
    else $error("step counts changed without an input transaction");

  assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into a full queue");

endmodule

[rtl/core/dsps_front.sv]
// Front end: accepts ticks, steps both motors and queues the phase byte.
// Depends on dsps_pkg.
module dsps_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_target_a,
  input  logic signed [15:0] in_target_b,
  input  logic               q_full,
  output logic               q_push,
  output dsps_pkg::job_t     q_job,
  output logic signed [15:0] count_a,
  output logic signed [15:0] count_b
);

  logic [3:0]         phase_a_r, phase_a_nxt;
  logic [3:0]         phase_b_r, phase_b_nxt;
  logic signed [15:0] count_a_r, count_a_nxt;
  logic signed [15:0] count_b_r, count_b_nxt;
  logic               accept;
  logic               moving;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign moving   = (count_a_r != in_target_a) || (count_b_r != in_target_b);
  assign q_push   = accept && moving;

  always_comb begin
    phase_a_nxt = phase_a_r;
    count_a_nxt = count_a_r;
    phase_b_nxt = phase_b_r;
    count_b_nxt = count_b_r;
    if (count_a_r > in_target_a) begin
      phase_a_nxt = {phase_a_r[0], phase_a_r[3:1]};
      count_a_nxt = count_a_r - 16'sd1;
    end else if (count_a_r < in_target_a) begin
      phase_a_nxt = {phase_a_r[2:0], phase_a_r[3]};
      count_a_nxt = count_a_r + 16'sd1;
    end
    if (count_b_r > in_target_b) begin
      phase_b_nxt = {phase_b_r[0], phase_b_r[3:1]};
      count_b_nxt = count_b_r - 16'sd1;
    end else if (count_b_r < in_target_b) begin
      phase_b_nxt = {phase_b_r[2:0], phase_b_r[3]};
      count_b_nxt = count_b_r + 16'sd1;
    end
  end

  assign q_job.data    = {phase_a_nxt, phase_b_nxt};
  assign q_job.count_a = count_a_nxt;
  assign q_job.count_b = count_b_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_a_r <= dsps_pkg::PHASE_RESET;
      phase_b_r <= dsps_pkg::PHASE_RESET;
      count_a_r <= '0;
      count_b_r <= '0;
    end else if (q_push) begin
      phase_a_r <= phase_a_nxt;
      phase_b_r <= phase_b_nxt;
      count_a_r <= count_a_nxt;
      count_b_r <= count_b_nxt;
    end
  end

  assign count_a = count_a_r;
  assign count_b = count_b_r;

endmodule

[rtl/core/dsps_queue.sv]
// Small job queue between the front end and the serializer.
// Depends on dsps_pkg.
module dsps_queue #(
  parameter int DEPTH = dsps_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dsps_pkg::job_t wr_job,
  output logic           full,
  input  logic           pop,
  output logic           rd_valid,
  output dsps_pkg::job_t rd_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  dsps_pkg::job_t    entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;

  assign full     = (fill_r == CNT_FULL);
  assign rd_valid = (fill_r != '0);
  assign rd_job   = entries[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

[rtl/core/dsps_back.sv]
// Back end: shifts each queued phase byte out MSB first, then a latch strobe.
// Depends on dsps_pkg.
module dsps_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  dsps_pkg::job_t     q_job,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_serial_bit,
  output logic               out_latch_pulse,
  output logic               out_last,
  output logic signed [15:0] out_count_a,
  output logic signed [15:0] out_count_b
);

  localparam logic [dsps_pkg::IDX_W-1:0] LATCH_IDX =
    dsps_pkg::IDX_W'(dsps_pkg::LATCH_IDX);

  logic                            busy_r, busy_nxt;
  logic [dsps_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic [dsps_pkg::DATA_BITS-1:0]  shift_r, shift_nxt;
  logic signed [15:0]              cnt_a_r, cnt_a_nxt;
  logic signed [15:0]              cnt_b_r, cnt_b_nxt;
  logic                            at_latch;
  logic                            done;

  assign at_latch = (idx_r == LATCH_IDX);
  assign done     = busy_r && out_ready && at_latch;
  assign q_pop    = q_valid && (!busy_r || done);

  always_comb begin
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    shift_nxt = shift_r;
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    if (q_pop) begin
      busy_nxt  = 1'b1;
      idx_nxt   = '0;
      shift_nxt = q_job.data;
      cnt_a_nxt = q_job.count_a;
      cnt_b_nxt = q_job.count_b;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r && out_ready) begin
      idx_nxt   = idx_r + dsps_pkg::IDX_W'(1);
      shift_nxt = {shift_r[dsps_pkg::DATA_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    cnt_a_r <= cnt_a_nxt;
    cnt_b_r <= cnt_b_nxt;
  end

  assign out_valid       = busy_r;
  assign out_serial_bit  = at_latch ? 1'b0 : shift_r[dsps_pkg::DATA_BITS-1];
  assign out_latch_pulse = at_latch;
  assign out_last        = at_latch;
  assign out_count_a     = cnt_a_r;
  assign out_count_b     = cnt_b_r;

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for dual_stepper_phase_sequencer: directed and random target ticks,
// with random idling on both channels, checked against an internal phase and count predictor.
// Depends on dsps_pkg and the dual_stepper_phase_sequencer RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic               serial_bit;
    logic               latch_pulse;
    logic               last;
    logic signed [15:0] count_a;
    logic signed [15:0] count_b;
  } serial_beat_t;

  class phase_scoreboard;
    logic [3:0]         phase_a;
    logic [3:0]         phase_b;
    logic signed [15:0] count_a;
    logic signed [15:0] count_b;
    serial_beat_t       pending_beats[$];
    int                 n_errors;

    function new();
      phase_a = dsps_pkg::PHASE_RESET;
      phase_b = dsps_pkg::PHASE_RESET;
      count_a = '0;
      count_b = '0;
      n_errors = 0;
    endfunction

    function void step_motor(inout logic [3:0] ph, inout logic signed [15:0] cnt,
                             input logic signed [15:0] tgt);
      if (cnt > tgt) begin
        ph = {ph[0], ph[3:1]};
        cnt = cnt - 16'sd1;
      end else if (cnt < tgt) begin
        ph = {ph[2:0], ph[3]};
        cnt = cnt + 16'sd1;
      end
    endfunction

    // Called for each accepted input transaction.
    function void note_tick(logic signed [15:0] tgt_a, logic signed [15:0] tgt_b);
      logic [dsps_pkg::DATA_BITS-1:0] frame;
      serial_beat_t                   beat;
      if (count_a == tgt_a && count_b == tgt_b) return;
      step_motor(phase_a, count_a, tgt_a);
      step_motor(phase_b, count_b, tgt_b);
      frame = {phase_a, phase_b};
      beat.count_a = count_a;
      beat.count_b = count_b;
      for (int k = 0; k <= dsps_pkg::DATA_BITS; k++) begin
        if (k < dsps_pkg::DATA_BITS) begin
          beat.serial_bit = frame[dsps_pkg::DATA_BITS-1-k];
          beat.latch_pulse = 1'b0;
          beat.last = 1'b0;
        end else begin
          beat.serial_bit = 1'b0;
          beat.latch_pulse = 1'b1;
          beat.last = 1'b1;
        end
        pending_beats.push_back(beat);
      end
    endfunction

    function int pending();
      return pending_beats.size();
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      n_errors++;
    endtask

    // Called for each accepted output transaction.
    task check_beat(serial_beat_t got);
      serial_beat_t want;
      if (pending_beats.size() == 0) begin
        report("output transaction with nothing expected");
        return;
      end
      want = pending_beats.pop_front();
      if (got.serial_bit !== want.serial_bit)
        report($sformatf("serial_bit got %b want %b", got.serial_bit, want.serial_bit));
      if (got.latch_pulse !== want.latch_pulse)
        report($sformatf("latch_pulse got %b want %b", got.latch_pulse, want.latch_pulse));
      if (got.last !== want.last)
        report($sformatf("last got %b want %b", got.last, want.last));
      if (got.count_a !== want.count_a)
        report($sformatf("count_a got %0d want %0d", got.count_a, want.count_a));
      if (got.count_b !== want.count_b)
        report($sformatf("count_b got %0d want %0d", got.count_b, want.count_b));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_target_a;
  logic signed [15:0] in_target_b;
  logic               out_valid;
  logic               out_ready;
  logic               out_serial_bit;
  logic               out_latch_pulse;
  logic               out_last;
  logic signed [15:0] out_count_a;
  logic signed [15:0] out_count_b;

  phase_scoreboard sb;
  int              send_idle_pct;
  int              recv_stall_pct;

  dual_stepper_phase_sequencer uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_target_a    (in_target_a),
    .in_target_b    (in_target_b),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_serial_bit (out_serial_bit),
    .out_latch_pulse(out_latch_pulse),
    .out_last       (out_last),
    .out_count_a    (out_count_a),
    .out_count_b    (out_count_b)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    serial_beat_t got;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready) begin
        got.serial_bit = out_serial_bit;
        got.latch_pulse = out_latch_pulse;
        got.last = out_last;
        got.count_a = out_count_a;
        got.count_b = out_count_b;
        sb.check_beat(got);
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_tick(logic signed [15:0] tgt_a, logic signed [15:0] tgt_b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_target_a <= tgt_a;
    in_target_b <= tgt_b;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(tgt_a, tgt_b);
  endtask

  task automatic send_random_tick();
    int                 mode;
    logic signed [15:0] tgt_a;
    logic signed [15:0] tgt_b;
    mode = $urandom_range(9);
    tgt_a = 16'(int'(sb.count_a) + int'($urandom_range(4)) - 2);
    tgt_b = 16'(int'(sb.count_b) + int'($urandom_range(4)) - 2);
    if (mode == 4) begin
      tgt_a = sb.count_a;
      tgt_b = 16'($urandom());
    end else if (mode == 5) begin
      tgt_a = 16'($urandom());
      tgt_b = sb.count_b;
    end else if (mode >= 6) begin
      tgt_a = 16'($urandom());
      tgt_b = 16'($urandom());
    end
    send_tick(tgt_a, tgt_b);
  endtask

  initial begin
    sb = new();
    send_idle_pct = 28;
    recv_stall_pct = 61;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_target_a = '0;
    in_target_b = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_tick(16'sd0, 16'sd0);
    send_tick(16'sd100, 16'sd0);
    send_tick(16'sd100, 16'sd0);
    send_tick(16'sd2, 16'sd0);
    send_tick(16'sd2, 16'sd5);
    send_tick(16'sd2, 16'sd1);
    send_tick(16'sh8000, 16'sd32767);
    send_tick(16'sd32767, 16'sh8000);
    send_tick(16'sd0, 16'sd0);
    send_tick(16'sd0, 16'sd0);
    send_tick(16'sd0, 16'sd0);
    send_tick(-16'sd1, -16'sd1);
    send_tick(-16'sd1, -16'sd1);
    send_tick(-16'sd5, -16'sd1);
    send_tick(-16'sd5, 16'sd3);
    send_tick(-16'sd5, 16'sd3);
    send_tick(-16'sd5, 16'sd3);
    send_tick(-16'sd5, 16'sd3);
    send_tick(16'sd32767, 16'sd32767);
    send_tick(16'sh8000, 16'sh8000);

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 61;
        recv_stall_pct = 28;
      end else if (ph == 2) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      for (int i = 0; i < 70; i++) send_random_tick();
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
